// ===== design/apac_pkg.sv =====
`timescale 1ns / 1ps
package apac_pkg;

	localparam int NUM_CHANNELS = 4;
	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	localparam logic [3:0] REQ_TICK      = 4'd0;
	localparam logic [3:0] REQ_ZERO_X    = 4'd1;
	localparam logic [3:0] REQ_MS_STEP   = 4'd2;
	localparam logic [3:0] REQ_SET_PCT   = 4'd3;
	localparam logic [3:0] REQ_SET_DELAY = 4'd4;
	localparam logic [3:0] REQ_ENABLE    = 4'd5;
	localparam logic [3:0] REQ_ATT_GATE  = 4'd6;
	localparam logic [3:0] REQ_ATT_RELAY = 4'd7;
	localparam logic [3:0] REQ_DETACH    = 4'd8;
	localparam logic [3:0] REQ_ALL_OFF   = 4'd9;

	localparam logic [2:0] CFG_HALF_CYCLE = 3'd0;
	localparam logic [2:0] CFG_MIN_DELAY  = 3'd1;
	localparam logic [2:0] CFG_MAX_DELAY  = 3'd2;
	localparam logic [2:0] CFG_PULSE      = 3'd3;
	localparam logic [2:0] CFG_THRESHOLD  = 3'd4;
	localparam logic [2:0] CFG_BREAK_MAKE = 3'd5;
	localparam logic [2:0] CFG_MIN_ON     = 3'd6;
	localparam logic [2:0] CFG_MIN_OFF    = 3'd7;

	localparam int F_ATT  = 0;
	localparam int F_EN   = 1;
	localparam int F_PACT = 2;
	localparam int F_PGEN = 3;
	localparam int F_RATT = 4;
	localparam int F_RACT = 5;

	localparam logic [1:0] PH_PHASE    = 2'd0;
	localparam logic [1:0] PH_WAIT_ON  = 2'd1;
	localparam logic [1:0] PH_HOLD     = 2'd2;
	localparam logic [1:0] PH_WAIT_OFF = 2'd3;

	localparam logic [6:0] PCT_FULL = 7'd100;
	localparam logic [15:0] RST_MAX_DELAY = 16'd9000;

	typedef struct packed {
		logic [3:0]  req_type;
		logic [2:0]  chan;
		logic [15:0] advance_us;
		logic        detector_alive;
		logic        detector_lost;
		logic [7:0]  pct_value;
		logic [15:0] delay_value;
		logic        enable_value;
	} req_word_t;

	typedef struct packed {
		logic [3:0] gate_bits;
		logic [3:0] relay_bits;
		logic       fault_status;
		logic       cmd_error;
		logic [6:0] read_pct;
		logic       read_enabled;
		logic       in_bypass;
		logic       any_pulsing;
	} rsp_word_t;

	typedef struct packed {
		logic [15:0] half_cycle_len_us;
		logic [15:0] min_fire_delay_us;
		logic [15:0] max_fire_delay_us;
		logic [15:0] pulse_width_us;
		logic [6:0]  bypass_threshold_pct;
		logic [15:0] break_make_ms;
		logic [15:0] relay_hold_ms;
		logic [15:0] relay_rest_ms;
	} cfg_t;

	typedef struct packed {
		logic [6:0]  pct;
		logic [15:0] delay;
		logic [5:0]  flags;
		logic [1:0]  phase;
		logic [31:0] on_stamp;
		logic [31:0] off_stamp;
	} chan_rec_t;

	localparam int REC_W = $bits(chan_rec_t);

	typedef struct packed {
		logic [3:0]  req_type;
		logic        sel;
		logic        alive;
		logic        lost;
		logic        ev;
		logic        win_act;
		logic        win_end;
		logic [15:0] total;
		logic [31:0] now;
		logic [6:0]  pct_new;
		logic [15:0] delay_new;
	} chan_ctx_t;

endpackage

// ===== design/apac_ram.sv =====
`timescale 1ns / 1ps
module apac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/apac_div.sv =====
`timescale 1ns / 1ps
module apac_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [22:0] num,
	input  logic [15:0] den,
	output logic        busy,
	output logic [22:0] quot
);
	logic [22:0] num_q;
	logic [15:0] rem_q;
	logic [15:0] den_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [16:0] sh;
	logic        fit;

	assign sh = {rem_q, num_q[22]};
	assign fit = sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 5'd22;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fit ? 16'(sh - {1'b0, den_q}) : sh[15:0];
			num_q <= {num_q[21:0], fit};
		end
	end

	assign busy = busy_q;
	assign quot = num_q;
endmodule

// ===== design/apac_chan_alu.sv =====
`timescale 1ns / 1ps
module apac_chan_alu (
	input  apac_pkg::cfg_t      cfg,
	input  apac_pkg::chan_ctx_t ctx,
	input  apac_pkg::chan_rec_t rec_i,
	output apac_pkg::chan_rec_t rec_o
);
	import apac_pkg::*;

	chan_rec_t r;
	logic [31:0] d_on;
	logic [31:0] d_off;
	logic want;
	logic on_ok;
	logic off_ok;
	logic bm_on;
	logic bm_off;

	assign d_on = ctx.now - rec_i.on_stamp;
	assign d_off = ctx.now - rec_i.off_stamp;
	assign want = rec_i.pct >= cfg.bypass_threshold_pct;
	assign on_ok = d_on >= {16'd0, cfg.relay_hold_ms};
	assign off_ok = d_off >= {16'd0, cfg.relay_rest_ms};
	assign bm_on = d_on >= {16'd0, cfg.break_make_ms};
	assign bm_off = d_off >= {16'd0, cfg.break_make_ms};

	always_comb begin
		r = rec_i;
		case (ctx.req_type)
			REQ_TICK: begin
				if (ctx.win_act) begin
					if (ctx.win_end) begin
						r.flags[F_PACT] = 1'b0;
						r.flags[F_PGEN] = 1'b0;
					end else if (!r.flags[F_ATT] || !r.flags[F_EN] || r.pct == 7'd0) begin
						r.flags[F_PACT] = 1'b0;
					end else if (r.phase != PH_PHASE) begin
						r.flags[F_PACT] = 1'b0;
						r.flags[F_PGEN] = 1'b1;
					end else begin
						if (!r.flags[F_PGEN] && ctx.total >= r.delay) begin
							r.flags[F_PGEN] = 1'b1;
							r.flags[F_PACT] = 1'b1;
						end
						if (r.flags[F_PACT] && (ctx.total < r.delay ||
								16'(ctx.total - r.delay) >= cfg.pulse_width_us)) begin
							r.flags[F_PACT] = 1'b0;
						end
					end
				end
			end
			REQ_ZERO_X: begin
				if (ctx.alive) begin
					r.flags[F_PACT] = 1'b0;
					r.flags[F_PGEN] = 1'b0;
				end
			end
			REQ_MS_STEP: begin
				if (ctx.lost) begin
					r.flags[F_PACT] = 1'b0;
					r.flags[F_PGEN] = 1'b0;
					r.flags[F_RACT] = 1'b0;
					r.phase = PH_PHASE;
				end else if (r.flags[F_ATT]) begin
					if (!r.flags[F_RATT]) begin
						r.flags[F_RACT] = 1'b0;
						r.phase = PH_PHASE;
					end else if (!r.flags[F_EN]) begin
						if (r.phase == PH_HOLD) begin
							if (on_ok) begin
								r.flags[F_RACT] = 1'b0;
								r.phase = PH_WAIT_OFF;
								r.off_stamp = ctx.now;
							end
						end else if (r.phase == PH_WAIT_OFF) begin
							if (bm_off) begin
								r.flags[F_RACT] = 1'b0;
								r.phase = PH_PHASE;
							end
						end else begin
							r.flags[F_RACT] = 1'b0;
							r.phase = PH_PHASE;
						end
					end else begin
						case (r.phase)
							PH_PHASE: begin
								if (want && off_ok) begin
									r.phase = PH_WAIT_ON;
									r.on_stamp = ctx.now;
								end
							end
							PH_WAIT_ON: begin
								if (bm_on) begin
									r.phase = PH_HOLD;
									r.flags[F_RACT] = 1'b1;
									r.on_stamp = ctx.now;
								end else if (!want) begin
									r.phase = PH_PHASE;
									r.flags[F_RACT] = 1'b0;
								end
							end
							PH_HOLD: begin
								if (!want && on_ok) begin
									r.flags[F_RACT] = 1'b0;
									r.phase = PH_WAIT_OFF;
									r.off_stamp = ctx.now;
								end
							end
							default: begin
								if (bm_off) begin
									r.phase = PH_PHASE;
									r.flags[F_RACT] = 1'b0;
								end
							end
						endcase
					end
				end
			end
			REQ_SET_PCT: begin
				if (ctx.sel) begin
					r.pct = ctx.pct_new;
					r.delay = ctx.delay_new;
					r.flags[F_PACT] = 1'b0;
					r.flags[F_EN] = ctx.pct_new != 7'd0;
					r.flags[F_PGEN] = ctx.pct_new != 7'd0;
				end
			end
			REQ_SET_DELAY: begin
				if (ctx.sel) begin
					r.pct = ctx.pct_new;
					r.delay = ctx.delay_new;
					r.flags[F_EN] = 1'b1;
					r.flags[F_PACT] = 1'b0;
					r.flags[F_PGEN] = 1'b1;
				end
			end
			REQ_ENABLE: begin
				if (ctx.sel) begin
					r.flags[F_EN] = ctx.ev;
					r.flags[F_PACT] = 1'b0;
					r.flags[F_PGEN] = ctx.ev;
				end
			end
			REQ_ATT_GATE: begin
				if (ctx.sel) begin
					r.delay = cfg.max_fire_delay_us;
					r.pct = 7'd0;
					r.flags[F_EN] = 1'b0;
					r.flags[F_PACT] = 1'b0;
					r.flags[F_PGEN] = 1'b0;
					r.flags[F_ATT] = 1'b1;
				end
			end
			REQ_ATT_RELAY: begin
				if (ctx.sel) begin
					r.flags[F_RACT] = 1'b0;
					r.flags[F_RATT] = 1'b1;
					r.phase = PH_PHASE;
					r.on_stamp = '0;
					r.off_stamp = '0;
				end
			end
			REQ_DETACH: begin
				if (ctx.sel) begin
					r.flags = '0;
					r.phase = PH_PHASE;
					r.delay = cfg.max_fire_delay_us;
					r.pct = 7'd0;
				end
			end
			REQ_ALL_OFF: begin
				if (r.flags[F_ATT]) begin
					r.flags[F_EN] = 1'b0;
					r.flags[F_PACT] = 1'b0;
					r.flags[F_PGEN] = 1'b0;
					r.flags[F_RACT] = 1'b0;
					r.phase = PH_PHASE;
				end
			end
			default: begin
			end
		endcase
	end

	assign rec_o = r;
endmodule

// ===== design/ac_phase_angle_controller_unit.sv =====
`timescale 1ns / 1ps
// Phase-angle controller with relay bypass, NUM_CHANNELS channels.
// cfg channel: cfg_valid/cfg_ready with cfg_index and cfg_data; always ready.
//   Write only while the block is idle.
// req channel: one word per item (tick, zero-cross, ms step, channel command,
//   all-off); taken when req_valid is high and req_stall is low.
// rsp channel: exactly one word per item, held while rsp_stall is high.
// Each item walks the per-channel record memory, one read and one write-back
// per channel (states RD then WR). The states run IDLE (item taken), PREP,
// DIVW, CALC, an RD/WR pair per channel, then FIN, which writes the word.
// The next item can be taken only after FIN returns to IDLE. set_delay with
// a delay strictly inside the limits waits in DIVW for the bit-serial divider.
// req_stall is high while an item is in work. A finished word waits in the
// output register; the next item is taken meanwhile and only its FIN state
// waits for the register to empty.
// After reset every channel reads as detached at zero percent, config holds
// its reset values, and no word is pending.
module ac_phase_angle_controller_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic                req_valid,
	output logic                req_stall,
	input  apac_pkg::req_word_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output apac_pkg::rsp_word_t rsp
);
	import apac_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_DIVW = 3'd2;
	localparam logic [2:0] ST_CALC = 3'd3;
	localparam logic [2:0] ST_RD   = 3'd4;
	localparam logic [2:0] ST_WR   = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;

	// ceil(2^30 / 100), exact for numerators below 2^23
	localparam logic [23:0] RECIP_100 = 24'd10737419;

	logic [2:0] state_q;
	cfg_t cfg_q;
	req_word_t item_q;
	rsp_word_t rsp_q;
	logic rsp_valid_q;

	logic [15:0] elapsed_q;
	logic        open_q;
	logic        fault_q;
	logic [31:0] ms_q;
	logic [9:0]  rem_q;

	logic [CH_W-1:0] ch_q;
	logic [NUM_CHANNELS-1:0] vld_q;
	logic rd_vld_q;
	logic [7:0] qest_q;
	logic [22:0] num3_q;
	logic [15:0] q3_q;
	logic [6:0] pct_new_q;
	logic [15:0] delay_new_q;
	logic [3:0] gate_q;
	logic [3:0] relay_q;
	logic anyp_q;
	logic [6:0] rp_q;
	logic re_q;
	logic rb_q;

	logic chan_ok;
	logic inv;
	logic [6:0] p_cl;
	logic [15:0] cd;
	logic [15:0] span;
	logic [16:0] total;
	logic win_act;
	logic win_end;
	logic [16:0] acc;
	logic [29:0] qprod;
	logic [46:0] q3_prod;
	logic [16:0] rr;
	logic fix;
	logic div_start;
	logic [22:0] div_num;
	logic [15:0] div_den;
	logic div_busy;
	logic [22:0] div_quot;
	logic need_div;
	logic [6:0] pct_calc;
	logic [15:0] delay_calc;
	logic is_t3;
	logic is_t4;

	chan_rec_t ram_rdata;
	chan_rec_t rec_cur;
	chan_rec_t rec_new;
	chan_ctx_t ctx;
	logic match;
	logic fault_nxt;
	logic is_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_cycle_len_us <= 16'd10000;
			cfg_q.min_fire_delay_us <= 16'd500;
			cfg_q.max_fire_delay_us <= RST_MAX_DELAY;
			cfg_q.pulse_width_us <= 16'd100;
			cfg_q.bypass_threshold_pct <= 7'd95;
			cfg_q.break_make_ms <= 16'd20;
			cfg_q.relay_hold_ms <= 16'd1000;
			cfg_q.relay_rest_ms <= 16'd1000;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_HALF_CYCLE: cfg_q.half_cycle_len_us <= cfg_data;
				CFG_MIN_DELAY:  cfg_q.min_fire_delay_us <= cfg_data;
				CFG_MAX_DELAY:  cfg_q.max_fire_delay_us <= cfg_data;
				CFG_PULSE:      cfg_q.pulse_width_us <= cfg_data;
				CFG_THRESHOLD:  cfg_q.bypass_threshold_pct <= cfg_data[6:0];
				CFG_BREAK_MAKE: cfg_q.break_make_ms <= cfg_data;
				CFG_MIN_ON:     cfg_q.relay_hold_ms <= cfg_data;
				CFG_MIN_OFF:    cfg_q.relay_rest_ms <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign chan_ok = {1'b0, item_q.chan} < 4'(NUM_CHANNELS);
	assign inv = cfg_q.max_fire_delay_us <= cfg_q.min_fire_delay_us;
	assign span = cfg_q.max_fire_delay_us - cfg_q.min_fire_delay_us;
	assign p_cl = (item_q.pct_value > 8'd100) ? PCT_FULL : item_q.pct_value[6:0];
	assign cd = (item_q.delay_value < cfg_q.min_fire_delay_us) ? cfg_q.min_fire_delay_us :
		((item_q.delay_value > cfg_q.max_fire_delay_us) ? cfg_q.max_fire_delay_us :
		item_q.delay_value);
	assign is_t3 = item_q.req_type == REQ_SET_PCT;
	assign is_t4 = item_q.req_type == REQ_SET_DELAY;
	assign total = {1'b0, elapsed_q} + {1'b0, item_q.advance_us};
	assign win_act = open_q && item_q.advance_us != 16'd0;
	assign win_end = total >= {1'b0, cfg_q.half_cycle_len_us};
	assign acc = {7'd0, rem_q} + {1'b0, item_q.advance_us};
	assign qprod = 30'(acc) * 30'd4194;
	assign rr = acc - 17'(qest_q * 17'd1000);
	assign fix = rr >= 17'd1000;
	assign q3_prod = 47'(num3_q) * 47'(RECIP_100);

	assign need_div = chan_ok && !inv && is_t4 &&
		cd > cfg_q.min_fire_delay_us && cd < cfg_q.max_fire_delay_us;
	assign div_start = (state_q == ST_PREP) && need_div;
	assign div_num = 23'(cd - cfg_q.min_fire_delay_us) * 23'(PCT_FULL);
	assign div_den = span;

	apac_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.busy  (div_busy),
		.quot  (div_quot)
	);

	always_comb begin
		if (is_t3) begin
			pct_calc = p_cl;
			if (inv) begin
				delay_calc = 16'd0;
			end else if (p_cl == PCT_FULL) begin
				delay_calc = cfg_q.min_fire_delay_us;
			end else if (p_cl == 7'd0) begin
				delay_calc = cfg_q.max_fire_delay_us;
			end else begin
				delay_calc = cfg_q.min_fire_delay_us + q3_q;
			end
		end else begin
			delay_calc = cd;
			if (inv || cd <= cfg_q.min_fire_delay_us) begin
				pct_calc = PCT_FULL;
			end else if (cd >= cfg_q.max_fire_delay_us) begin
				pct_calc = 7'd0;
			end else begin
				pct_calc = PCT_FULL - div_quot[6:0];
			end
		end
	end

	assign match = chan_ok && (item_q.chan == 3'(ch_q));
	assign is_cmd = item_q.req_type >= REQ_SET_PCT && item_q.req_type <= REQ_DETACH;

	assign ctx.req_type = item_q.req_type;
	assign ctx.sel = match;
	assign ctx.alive = item_q.detector_alive;
	assign ctx.lost = item_q.detector_lost;
	assign ctx.ev = item_q.enable_value;
	assign ctx.win_act = win_act;
	assign ctx.win_end = win_end;
	assign ctx.total = total[15:0];
	assign ctx.now = ms_q;
	assign ctx.pct_new = pct_new_q;
	assign ctx.delay_new = delay_new_q;

	apac_ram #(
		.WIDTH(REC_W),
		.DEPTH(NUM_CHANNELS)
	) u_ram (
		.clk  (clk),
		.we   (state_q == ST_WR),
		.waddr(ch_q),
		.wdata(rec_new),
		.raddr(ch_q),
		.rdata(ram_rdata)
	);

	always_comb begin
		rec_cur = ram_rdata;
		if (!rd_vld_q) begin
			rec_cur = '0;
			rec_cur.delay = RST_MAX_DELAY;
		end
	end

	apac_chan_alu u_alu (
		.cfg  (cfg_q),
		.ctx  (ctx),
		.rec_i(rec_cur),
		.rec_o(rec_new)
	);

	always_comb begin
		fault_nxt = fault_q;
		if (item_q.req_type == REQ_ZERO_X && item_q.detector_alive) begin
			fault_nxt = 1'b0;
		end else if (item_q.req_type == REQ_MS_STEP && item_q.detector_lost) begin
			fault_nxt = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			vld_q <= '0;
			elapsed_q <= '0;
			open_q <= 1'b0;
			fault_q <= 1'b0;
			ms_q <= '0;
			rem_q <= '0;
			ch_q <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != ST_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: state_q <= ST_DIVW;
				ST_DIVW: begin
					if (!div_busy) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					ch_q <= '0;
					state_q <= ST_RD;
				end
				ST_RD: state_q <= ST_WR;
				ST_WR: begin
					vld_q[ch_q] <= 1'b1;
					if (ch_q == CH_W'(NUM_CHANNELS - 1)) begin
						state_q <= ST_FIN;
					end else begin
						ch_q <= ch_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_FIN: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						state_q <= ST_IDLE;
						fault_q <= fault_nxt;
						case (item_q.req_type)
							REQ_TICK: begin
								if (win_act) begin
									if (win_end) begin
										elapsed_q <= '0;
										open_q <= 1'b0;
									end else begin
										elapsed_q <= total[15:0];
									end
								end
								ms_q <= ms_q + 32'(qest_q) + 32'(fix);
								rem_q <= fix ? 10'(rr - 17'd1000) : rr[9:0];
							end
							REQ_ZERO_X: begin
								if (item_q.detector_alive) begin
									elapsed_q <= '0;
									open_q <= 1'b1;
								end
							end
							REQ_MS_STEP: begin
								if (item_q.detector_lost) begin
									elapsed_q <= '0;
									open_q <= 1'b0;
								end
							end
							REQ_ALL_OFF: begin
								elapsed_q <= '0;
								open_q <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					item_q <= req;
				end
			end
			ST_PREP: begin
				qest_q <= qprod[29:22];
				num3_q <= 23'(span) * 23'(PCT_FULL - p_cl);
			end
			ST_DIVW: q3_q <= q3_prod[45:30];
			ST_CALC: begin
				pct_new_q <= pct_calc;
				delay_new_q <= delay_calc;
				gate_q <= '0;
				relay_q <= '0;
				anyp_q <= 1'b0;
				rp_q <= '0;
				re_q <= 1'b0;
				rb_q <= 1'b0;
			end
			ST_RD: rd_vld_q <= vld_q[ch_q];
			ST_WR: begin
				if (rec_new.flags[F_PACT]) begin
					anyp_q <= 1'b1;
				end
				for (int i = 0; i < 4; i++) begin
					if (3'(ch_q) == 3'(i) && rec_new.flags[F_ATT] && rec_new.flags[F_EN]) begin
						if (rec_new.flags[F_PACT] && rec_new.phase == PH_PHASE) begin
							gate_q[i] <= 1'b1;
						end
						if (rec_new.flags[F_RATT] && rec_new.flags[F_RACT]) begin
							relay_q[i] <= 1'b1;
						end
					end
				end
				if (match) begin
					rp_q <= rec_new.pct;
					re_q <= rec_new.flags[F_EN];
					rb_q <= rec_new.phase == PH_HOLD;
				end
			end
			ST_FIN: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_q.gate_bits <= gate_q;
					rsp_q.relay_bits <= relay_q;
					rsp_q.fault_status <= fault_nxt;
					rsp_q.cmd_error <= is_cmd && !chan_ok;
					rsp_q.read_pct <= rp_q;
					rsp_q.read_enabled <= re_q;
					rsp_q.in_bypass <= rb_q;
					rsp_q.any_pulsing <= anyp_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign req_stall = state_q != ST_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
endmodule

// ===== design/apac_checker.sv =====
`timescale 1ns / 1ps
module apac_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_stall,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input apac_pkg::rsp_word_t rsp
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("rsp word changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second word taken before first finished");

	a_err_readback: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.cmd_error |->
		rsp.read_pct == 7'd0 && !rsp.read_enabled && !rsp.in_bypass)
		else $error("readback on bad channel");

	a_gate_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.gate_bits != 4'd0 |-> rsp.any_pulsing)
		else $error("gate without pulse");
endmodule

bind ac_phase_angle_controller_unit apac_checker u_chk (.*);
